FILE: rtl/core/asid_binding_lru_select_assert.svh
// assertion macros for the asid binding block
`ifndef ASID_BINDING_LRU_SELECT_ASSERT_SVH
`define ASID_BINDING_LRU_SELECT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ALBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("albs check failed");

// next-cycle implication, checked outside reset
`define ALBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("albs check failed");

`endif

FILE: rtl/core/albs_pkg.sv
`default_nettype none

package albs_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SPACE_W   = 16;
    localparam int STAMP_W   = 64;
    localparam int IDX_OUT_W = 3;
    localparam int OUT_W     = 24;

    typedef logic [SLOT_W-1:0]  t_slot_idx;
    typedef logic [SPACE_W-1:0] t_space;
    typedef logic [STAMP_W-1:0] t_stamp;

    // search token handed from cell to cell
    typedef struct packed {
        logic      active;
        logic      found;
        t_space    sid;
        t_slot_idx chosen;
        t_stamp    best_stamp;
        t_slot_idx best_idx;
        logic      best_valid;
        t_space    best_space;
    } t_token;

    // update broadcast to all cells
    typedef struct packed {
        logic      en;
        t_slot_idx idx;
        t_space    space;
        t_stamp    stamp;
    } t_wr;

endpackage

`default_nettype wire

FILE: rtl/core/albs_cell.sv
`default_nettype none

module albs_cell
    import albs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_slot_idx i_slot_idx,
    input  wire t_token    i_tok,
    input  wire t_wr       i_wr,
    output t_token         o_tok
);

    logic   r_valid;
    t_space r_space;
    t_stamp r_stamp;
    t_token r_tok;
    t_token n_tok;

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.found) begin
            if (r_valid && (r_space == i_tok.sid)) begin
                n_tok.found  = 1'b1;
                n_tok.chosen = i_slot_idx;
            end else if ((i_slot_idx == '0) || (r_stamp < i_tok.best_stamp)) begin
                // strict less keeps the lowest index on ties
                n_tok.best_stamp = r_stamp;
                n_tok.best_idx   = i_slot_idx;
                n_tok.best_valid = r_valid;
                n_tok.best_space = r_space;
            end
        end
    end

    // token payload only matters while active, so reset clears just the flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_stamp      <= '0;
            r_tok.active <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.en && (i_wr.idx == i_slot_idx)) begin
                r_valid <= 1'b1;
                r_stamp <= i_wr.stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_slot_idx)) begin
            r_space <= i_wr.space;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: rtl/core/asid_binding_lru_select.sv
// channel   | dir | tdata fields (lsb first)
// ----------+-----+---------------------------------------------------------------
// s_axis    | in  | space_id[15:0]
// m_axis    | out | binding_index[2:0] hit table_switch flush_needed evicted_valid
//           |     | evicted_space[15:0], one zero pad bit
//
// for each request a search token walks the row of
// binding cells one cell per cycle, then the finish stage applies the
// update and loads the result register.
// synchronous active-low reset clears every binding, the primary mark and
// sets the stamp counter to one. a stalled result holds the update in the
// finish stage; the next request is taken as soon as the update is done.
`default_nettype none

module asid_binding_lru_select
    import albs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [SPACE_W-1:0] i_s_axis_tdata,   // space_id[15:0]
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    // binding_index[2:0], hit[3], table_switch[4], flush_needed[5],
    // evicted_valid[6], evicted_space[22:7], zero pad[23]
    output logic [OUT_W-1:0]        o_m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state    r_state, n_state;
    t_slot_idx r_prim_slot;
    logic      r_prim_valid;
    t_stamp    r_stamp_ctr;
    t_token    r_fin;
    logic      r_o_valid;
    logic [OUT_W-1:0] r_o_data, n_o_data;

    t_token w_tok [NUM_SLOTS+1];
    t_wr    w_wr;
    logic   w_in_beat;
    logic   w_out_free;
    logic   w_finish;
    logic   w_is_prim;
    logic   w_ev_valid;
    t_space w_ev_space;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_o_valid || i_m_axis_tready;
    assign w_finish        = (r_state == ST_FIN) && w_out_free;

    // token launched into the first cell on the input beat
    always_comb begin
        w_tok[0]            = '0;
        w_tok[0].active     = w_in_beat;
        w_tok[0].sid        = i_s_axis_tdata;
    end

    // row of binding cells, each passes the token to the next
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        albs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_slot_idx (t_slot_idx'(g)),
            .i_tok      (w_tok[g]),
            .i_wr       (w_wr),
            .o_tok      (w_tok[g+1])
        );
    end

    // decide the update from the finished token
    always_comb begin
        w_is_prim  = r_prim_valid && (r_prim_slot == r_fin.chosen);
        w_wr.en    = w_finish && (!r_fin.found || !w_is_prim);
        w_wr.idx   = r_fin.found ? r_fin.chosen : r_fin.best_idx;
        w_wr.space = r_fin.sid;
        w_wr.stamp = r_stamp_ctr;
        w_ev_valid = !r_fin.found && r_fin.best_valid;
        w_ev_space = w_ev_valid ? r_fin.best_space : '0;
        n_o_data   = {1'b0, w_ev_space, w_ev_valid, !r_fin.found,
                      (!r_fin.found || !w_is_prim), r_fin.found,
                      IDX_OUT_W'(w_wr.idx)};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_beat) n_state = ST_SCAN;
            ST_SCAN: if (w_tok[NUM_SLOTS].active) n_state = ST_FIN;
            ST_FIN:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prim_slot  <= '0;
            r_prim_valid <= 1'b0;
            r_stamp_ctr  <= STAMP_W'(1);
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr.en) begin
                r_prim_slot  <= w_wr.idx;
                r_prim_valid <= 1'b1;
                r_stamp_ctr  <= r_stamp_ctr + STAMP_W'(1);
            end
            if (w_finish) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN) && w_tok[NUM_SLOTS].active) begin
            r_fin <= w_tok[NUM_SLOTS];
        end
        if (w_finish) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

endmodule

`default_nettype wire

FILE: rtl/core/albs_check.sv
`default_nettype none

`include "asid_binding_lru_select_assert.svh"

module albs_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_tvalid,
    input wire logic        i_out_tready,
    input wire logic [23:0] i_out_tdata
);

    // a flush always comes with a table switch
    `ALBS_ASSERT_NOW(a_flush_switch, i_clk, i_rst_n, i_out_tvalid && i_out_tdata[5], i_out_tdata[4])
    // an eviction only on a miss
    `ALBS_ASSERT_NOW(a_evict_miss, i_clk, i_rst_n, i_out_tvalid && i_out_tdata[6], i_out_tdata[5] && !i_out_tdata[3])
    // no eviction means a zero evicted space
    `ALBS_ASSERT_NOW(a_evict_zero, i_clk, i_rst_n, i_out_tvalid && !i_out_tdata[6], i_out_tdata[22:7] == 16'd0)
    // a stalled result beat stays offered
    `ALBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_tvalid && !i_out_tready, i_out_tvalid)

endmodule

bind asid_binding_lru_select albs_check u_albs_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_tvalid (o_m_axis_tvalid),
    .i_out_tready (i_m_axis_tready),
    .i_out_tdata  (o_m_axis_tdata)
);

`default_nettype wire
